### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

### rtl/ubxpvt_pkg.sv
// Types, constants and field table of the NAV-PVT frame parser.
package ubxpvt_pkg;

   localparam int MAX_FRAME_BYTES = 256;
   localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W           = 17;
   localparam int CMP_W           = LEN_W + 1;
   localparam int FRAME_OVERHEAD  = 8;
   localparam int LEN_LO_INDEX    = 4;

   localparam int STORE_LO        = 6;
   localparam int STORE_DEPTH     = 80;
   localparam int STORE_AW        = $clog2(STORE_DEPTH);
   localparam int ROW_BYTES       = 4;
   localparam int LANE_W          = $clog2(ROW_BYTES);
   localparam int ROW_COUNT       = STORE_DEPTH / ROW_BYTES;
   localparam int ROW_W           = STORE_AW - LANE_W;

   localparam int FIELD_ID_W      = 5;
   localparam int VALUE_W         = 33;
   localparam int TOTAL_W         = 16;

   localparam logic [7:0] SYNC_1    = 8'hB5;
   localparam logic [7:0] SYNC_2    = 8'h62;
   localparam logic [7:0] MSG_CLASS = 8'h01;
   localparam logic [7:0] MSG_ID    = 8'h07;
   localparam logic [7:0] FIX_3D    = 8'd3;
   localparam logic [7:0] FIX_GNSS_DR = 8'd4;

   localparam logic [STORE_AW-1:0]   FIX_OFFSET = STORE_AW'(20);
   localparam logic [FIELD_ID_W-1:0] LAST_BASIC = FIELD_ID_W'(8);
   localparam logic [FIELD_ID_W-1:0] LAST_FULL  = FIELD_ID_W'(22);

   typedef enum logic [2:0] {
      ST_BYTE  = 3'd0,
      ST_HDR   = 3'd1,
      ST_OVF   = 3'd2,
      ST_CSUM  = 3'd3,
      ST_FIELD = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_U1 = 2'd0,
      KIND_U2 = 2'd1,
      KIND_U4 = 2'd2,
      KIND_I4 = 2'd3
   } kind_type;

   typedef struct packed {
      logic [STORE_AW-1:0] offset;
      kind_type            kind;
   } field_spec_type;

   typedef struct packed {
      status_type                   status;
      logic [FIELD_ID_W-1:0]        field_id;
      logic signed [VALUE_W-1:0]    field_value;
      logic                         last;
      logic [TOTAL_W-1:0]           overflow_total;
      logic [TOTAL_W-1:0]           fix_frame_total;
   } rsp_item_type;

   function automatic field_spec_type field_spec(input logic [FIELD_ID_W-1:0] id);
      field_spec_type s;
      s.offset = '0;
      s.kind   = KIND_U1;
      case (id)
         5'd0:  begin s.offset = STORE_AW'(0);  s.kind = KIND_U4; end
         5'd1:  begin s.offset = STORE_AW'(4);  s.kind = KIND_U2; end
         5'd2:  begin s.offset = STORE_AW'(6);  s.kind = KIND_U1; end
         5'd3:  begin s.offset = STORE_AW'(7);  s.kind = KIND_U1; end
         5'd4:  begin s.offset = STORE_AW'(8);  s.kind = KIND_U1; end
         5'd5:  begin s.offset = STORE_AW'(9);  s.kind = KIND_U1; end
         5'd6:  begin s.offset = STORE_AW'(10); s.kind = KIND_U1; end
         5'd7:  begin s.offset = STORE_AW'(16); s.kind = KIND_I4; end
         5'd8:  begin s.offset = FIX_OFFSET;    s.kind = KIND_U1; end
         5'd9:  begin s.offset = STORE_AW'(28); s.kind = KIND_I4; end
         5'd10: begin s.offset = STORE_AW'(24); s.kind = KIND_I4; end
         5'd11: begin s.offset = STORE_AW'(48); s.kind = KIND_I4; end
         5'd12: begin s.offset = STORE_AW'(52); s.kind = KIND_I4; end
         5'd13: begin s.offset = STORE_AW'(56); s.kind = KIND_I4; end
         5'd14: begin s.offset = STORE_AW'(64); s.kind = KIND_I4; end
         5'd15: begin s.offset = STORE_AW'(60); s.kind = KIND_I4; end
         5'd16: begin s.offset = STORE_AW'(36); s.kind = KIND_I4; end
         5'd17: begin s.offset = STORE_AW'(32); s.kind = KIND_I4; end
         5'd18: begin s.offset = STORE_AW'(76); s.kind = KIND_U2; end
         5'd19: begin s.offset = STORE_AW'(68); s.kind = KIND_U4; end
         5'd20: begin s.offset = STORE_AW'(40); s.kind = KIND_U4; end
         5'd21: begin s.offset = STORE_AW'(44); s.kind = KIND_U4; end
         5'd22: begin s.offset = STORE_AW'(23); s.kind = KIND_U1; end
         default: begin s.offset = '0; s.kind = KIND_U1; end
      endcase
      return s;
   endfunction

endpackage

### rtl/ubxpvt_if.sv
// Valid/ready channel interfaces for receiver bytes and parser results.
interface ubxpvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface ubxpvt_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [2:0]                               status;
   logic [ubxpvt_pkg::FIELD_ID_W-1:0]        field_id;
   logic signed [ubxpvt_pkg::VALUE_W-1:0]    field_value;
   logic                                     last;
   logic [ubxpvt_pkg::TOTAL_W-1:0]           overflow_total;
   logic [ubxpvt_pkg::TOTAL_W-1:0]           fix_frame_total;

   modport source (output valid, output status, output field_id, output field_value,
                   output last, output overflow_total, output fix_frame_total,
                   input ready);
   modport sink   (input valid, input status, input field_id, input field_value,
                   input last, input overflow_total, input fix_frame_total,
                   output ready);
endinterface

### rtl/ubx_nav_pvt_frame_parser.sv
// NAV-PVT frame parser: one byte per item in, status and field items out.
// A byte's status item is registered into the result queue when the byte is taken.
// Throughput: one byte per cycle while the result queue has room; a good frame then
//   stalls input while its 9 or 23 fields are read, one payload row per cycle while the queue has room.
// Reset: synchronous, active high; clears parser state, counters, store valid
//   bits and the two-entry result queue.
`include "assert_macros.svh"

module ubx_nav_pvt_frame_parser (
   input logic           clock,
   input logic           reset,
   ubxpvt_req_if.sink    req_ch,
   ubxpvt_rsp_if.source  rsp_ch
);

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [5:0] {
      PH_SYNC1 = 6'b000001,
      PH_SYNC2 = 6'b000010,
      PH_CLASS = 6'b000100,
      PH_ID    = 6'b001000,
      PH_LEN   = 6'b010000,
      PH_BODY  = 6'b100000
   } phase_type;

   // parser state
   phase_type                         phase_ff, phase_in;
   logic [ubxpvt_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [ubxpvt_pkg::LEN_W-1:0]      flen_ff, flen_in;
   logic [7:0]                        sum_a_ff, sum_a_in;
   logic [7:0]                        sum_b_ff, sum_b_in;
   logic [7:0]                        cka_ff, cka_in;
   logic [7:0]                        fix_ff, fix_in;
   logic [ubxpvt_pkg::TOTAL_W-1:0]    ovf_ff, ovf_in;
   logic [ubxpvt_pkg::TOTAL_W-1:0]    fixcnt_ff, fixcnt_in;

   logic                              req_take;
   logic [7:0]                        rx_byte;
   logic [ubxpvt_pkg::CMP_W-1:0]      idx_ext, idx_p1, idx_p3, flen_ext;
   logic [ubxpvt_pkg::CMP_W-1:0]      wa_full;
   logic [ubxpvt_pkg::STORE_AW-1:0]   wa;
   logic                              st_we;
   logic                              add_sum;
   logic                              mismatch;
   logic                              frame_ok;
   logic                              fix_good;
   logic [7:0]                        sum_a_add;
   ubxpvt_pkg::status_type            byte_status;

   // payload store, 32-bit rows with per-byte valid bits
   logic [31:0]                       store_mem [ubxpvt_pkg::ROW_COUNT];
   logic [ubxpvt_pkg::ROW_BYTES-1:0]  vld_ff [ubxpvt_pkg::ROW_COUNT];
   logic [31:0]                       rd_word_ff;
   logic [ubxpvt_pkg::ROW_BYTES-1:0]  rd_vld_ff;

   // field burst
   logic                              burst_ff, burst_in;
   logic                              full_ff, full_in;
   logic [ubxpvt_pkg::FIELD_ID_W-1:0] fld_ff, fld_in;
   logic [ubxpvt_pkg::FIELD_ID_W-1:0] last_id;
   logic                              rdv_ff, rdv_in;
   logic [ubxpvt_pkg::FIELD_ID_W-1:0] rd_id_ff;
   logic                              rd_last_ff;
   logic                              rd_issue;
   logic                              rd_push;
   ubxpvt_pkg::field_spec_type        issue_spec, rd_spec;
   logic [31:0]                       rd_masked, rd_shift;
   logic signed [ubxpvt_pkg::VALUE_W-1:0] rd_value;

   // result queue
   ubxpvt_pkg::rsp_item_type          fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]                wp_ff, rp_ff;
   logic [FIFO_CW-1:0]                cnt_ff, cnt_in;
   logic                              push, pop, fifo_room;
   ubxpvt_pkg::rsp_item_type          push_item, head;

   assign req_ch.ready = !burst_ff && !rdv_ff && (cnt_ff != FIFO_CW'(FIFO_DEPTH));
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rx_byte      = req_ch.in_byte;

   assign idx_ext  = ubxpvt_pkg::CMP_W'(count_ff);
   assign idx_p1   = idx_ext + ubxpvt_pkg::CMP_W'(1);
   assign idx_p3   = idx_ext + ubxpvt_pkg::CMP_W'(3);
   assign flen_ext = ubxpvt_pkg::CMP_W'(flen_ff);
   assign wa_full  = idx_ext - ubxpvt_pkg::CMP_W'(ubxpvt_pkg::STORE_LO);
   assign wa       = wa_full[ubxpvt_pkg::STORE_AW-1:0];
   assign sum_a_add = sum_a_ff + rx_byte;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      flen_in     = flen_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      cka_in      = cka_ff;
      fix_in      = fix_ff;
      ovf_in      = ovf_ff;
      fixcnt_in   = fixcnt_ff;
      byte_status = ubxpvt_pkg::ST_BYTE;
      st_we       = 1'b0;
      add_sum     = 1'b0;
      mismatch    = 1'b0;
      frame_ok    = 1'b0;
      fix_good    = 1'b0;
      if (req_take) begin
         if (count_ff >= ubxpvt_pkg::COUNT_W'(ubxpvt_pkg::MAX_FRAME_BYTES)) begin
            ovf_in      = ovf_ff + 1'b1;
            byte_status = ubxpvt_pkg::ST_OVF;
            phase_in    = PH_SYNC1;
            count_in    = '0;
         end else begin
            count_in = count_ff + 1'b1;
            st_we = (idx_ext >= ubxpvt_pkg::CMP_W'(ubxpvt_pkg::STORE_LO)) &&
                    (wa_full < ubxpvt_pkg::CMP_W'(ubxpvt_pkg::STORE_DEPTH));
            if (st_we && wa == ubxpvt_pkg::FIX_OFFSET) begin
               fix_in = rx_byte;
            end
            fix_good = (fix_in == ubxpvt_pkg::FIX_3D) || (fix_in == ubxpvt_pkg::FIX_GNSS_DR);
            case (phase_ff)
               PH_SYNC1: begin
                  if (rx_byte == ubxpvt_pkg::SYNC_1) begin
                     phase_in = PH_SYNC2;
                     sum_a_in = '0;
                     sum_b_in = '0;
                  end else begin
                     mismatch = 1'b1;
                  end
               end
               PH_SYNC2: begin
                  if (rx_byte == ubxpvt_pkg::SYNC_2) begin
                     phase_in = PH_CLASS;
                  end else begin
                     mismatch = 1'b1;
                  end
               end
               PH_CLASS: begin
                  if (rx_byte == ubxpvt_pkg::MSG_CLASS) begin
                     add_sum  = 1'b1;
                     phase_in = PH_ID;
                  end else begin
                     mismatch = 1'b1;
                  end
               end
               PH_ID: begin
                  if (rx_byte == ubxpvt_pkg::MSG_ID) begin
                     add_sum  = 1'b1;
                     phase_in = PH_LEN;
                  end else begin
                     mismatch = 1'b1;
                  end
               end
               PH_LEN: begin
                  add_sum = 1'b1;
                  if (count_ff == ubxpvt_pkg::COUNT_W'(ubxpvt_pkg::LEN_LO_INDEX)) begin
                     flen_in = ubxpvt_pkg::LEN_W'(rx_byte);
                  end else begin
                     flen_in  = ubxpvt_pkg::LEN_W'({rx_byte, flen_ff[7:0]}) +
                                ubxpvt_pkg::LEN_W'(ubxpvt_pkg::FRAME_OVERHEAD);
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (idx_p1 < flen_ext) begin
                     if (idx_p3 <= flen_ext) begin
                        add_sum = 1'b1;
                     end else begin
                        cka_in = rx_byte;
                     end
                  end else begin
                     phase_in = PH_SYNC1;
                     count_in = '0;
                     if (sum_a_ff != cka_ff || sum_b_ff != rx_byte) begin
                        byte_status = ubxpvt_pkg::ST_CSUM;
                     end else begin
                        frame_ok = 1'b1;
                        if (fix_good) begin
                           fixcnt_in = fixcnt_ff + 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  mismatch = 1'b1;
               end
            endcase
            if (mismatch) begin
               byte_status = ubxpvt_pkg::ST_HDR;
               phase_in    = PH_SYNC1;
               count_in    = '0;
            end
            if (add_sum) begin
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_ff + sum_a_add;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         count_ff  <= '0;
         flen_ff   <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         cka_ff    <= '0;
         fix_ff    <= '0;
         ovf_ff    <= '0;
         fixcnt_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         flen_ff   <= flen_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         cka_ff    <= cka_in;
         fix_ff    <= fix_in;
         ovf_ff    <= ovf_in;
         fixcnt_ff <= fixcnt_in;
      end
   end

   // field burst sequencing
   assign last_id    = full_ff ? ubxpvt_pkg::LAST_FULL : ubxpvt_pkg::LAST_BASIC;
   assign pop        = (cnt_ff != '0) && rsp_ch.ready;
   assign fifo_room  = (cnt_ff != FIFO_CW'(FIFO_DEPTH)) || pop;
   assign rd_push    = rdv_ff && fifo_room;
   assign rd_issue   = burst_ff && (!rdv_ff || rd_push);
   assign issue_spec = ubxpvt_pkg::field_spec(fld_ff);

   always_comb begin
      burst_in = burst_ff;
      full_in  = full_ff;
      fld_in   = fld_ff;
      rdv_in   = rdv_ff;
      if (frame_ok) begin
         burst_in = 1'b1;
         full_in  = fix_good;
         fld_in   = '0;
      end else if (rd_issue) begin
         if (fld_ff == last_id) begin
            burst_in = 1'b0;
         end else begin
            fld_in = fld_ff + 1'b1;
         end
      end
      if (rd_issue) begin
         rdv_in = 1'b1;
      end else if (rd_push) begin
         rdv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= 1'b0;
         full_ff  <= 1'b0;
         fld_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         burst_ff <= burst_in;
         full_ff  <= full_in;
         fld_ff   <= fld_in;
         rdv_ff   <= rdv_in;
      end
   end

   // store write and row read
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[wa[ubxpvt_pkg::STORE_AW-1:ubxpvt_pkg::LANE_W]]
                  [{wa[ubxpvt_pkg::LANE_W-1:0], 3'b000} +: 8] <= rx_byte;
      end
      if (rd_issue) begin
         rd_word_ff <= store_mem[issue_spec.offset[ubxpvt_pkg::STORE_AW-1:ubxpvt_pkg::LANE_W]];
         rd_vld_ff  <= vld_ff[issue_spec.offset[ubxpvt_pkg::STORE_AW-1:ubxpvt_pkg::LANE_W]];
         rd_id_ff   <= fld_ff;
         rd_last_ff <= (fld_ff == last_id);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ubxpvt_pkg::ROW_COUNT; r++) begin
            vld_ff[r] <= '0;
         end
      end else if (st_we) begin
         vld_ff[wa[ubxpvt_pkg::STORE_AW-1:ubxpvt_pkg::LANE_W]][wa[ubxpvt_pkg::LANE_W-1:0]] <= 1'b1;
      end
   end

   // field formatting; bytes never written read as zero
   assign rd_spec   = ubxpvt_pkg::field_spec(rd_id_ff);
   assign rd_masked = rd_word_ff & {{8{rd_vld_ff[3]}}, {8{rd_vld_ff[2]}},
                                    {8{rd_vld_ff[1]}}, {8{rd_vld_ff[0]}}};
   assign rd_shift  = rd_masked >> {rd_spec.offset[ubxpvt_pkg::LANE_W-1:0], 3'b000};

   always_comb begin
      case (rd_spec.kind)
         ubxpvt_pkg::KIND_U1: rd_value = ubxpvt_pkg::VALUE_W'(rd_shift[7:0]);
         ubxpvt_pkg::KIND_U2: rd_value = ubxpvt_pkg::VALUE_W'(rd_shift[15:0]);
         ubxpvt_pkg::KIND_U4: rd_value = ubxpvt_pkg::VALUE_W'(rd_shift);
         ubxpvt_pkg::KIND_I4: rd_value = {rd_shift[31], rd_shift};
         default:             rd_value = '0;
      endcase
   end

   // result queue
   assign push = (req_take && !frame_ok) || rd_push;

   always_comb begin
      if (rd_push) begin
         push_item.status          = ubxpvt_pkg::ST_FIELD;
         push_item.field_id        = rd_id_ff;
         push_item.field_value     = rd_value;
         push_item.last            = rd_last_ff;
         push_item.overflow_total  = ovf_ff;
         push_item.fix_frame_total = fixcnt_ff;
      end else begin
         push_item.status          = byte_status;
         push_item.field_id        = '0;
         push_item.field_value     = '0;
         push_item.last            = 1'b1;
         push_item.overflow_total  = ovf_in;
         push_item.fix_frame_total = fixcnt_in;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   assign head                   = fifo_ff[rp_ff];
   assign rsp_ch.valid           = (cnt_ff != '0);
   assign rsp_ch.status          = head.status;
   assign rsp_ch.field_id        = head.field_id;
   assign rsp_ch.field_value     = head.field_value;
   assign rsp_ch.last            = head.last;
   assign rsp_ch.overflow_total  = head.overflow_total;
   assign rsp_ch.fix_frame_total = head.fix_frame_total;

   `ASSERT_NEVER(a_take_in_burst, req_take && (burst_ff || rdv_ff), "byte taken during field burst")
   `ASSERT_NEVER(a_fifo_overrun, push && !pop && (cnt_ff == FIFO_CW'(FIFO_DEPTH)), "result queue overrun")
   `ASSERT_CLK(a_burst_end_id, rd_push && rd_last_ff |-> (rd_id_ff == ubxpvt_pkg::LAST_BASIC) || (rd_id_ff == ubxpvt_pkg::LAST_FULL), "burst ended on wrong field")
   `ASSERT_CLK(a_fix_count_src, !$past(reset) && (fixcnt_ff != $past(fixcnt_ff)) |-> $past(frame_ok), "fix counter moved without a good frame")

endmodule

### sim/tb.sv
// Self-checking testbench for the NAV-PVT frame parser: byte stimulus, field prediction.
`timescale 1ns / 1ps

typedef logic [7:0] byte_q_type [$];

typedef enum int {
   HUNT_SYNC1,
   HUNT_SYNC2,
   WANT_CLASS,
   WANT_ID,
   GET_LEN,
   GET_BODY
} parse_phase_type;

typedef enum logic [ubxpvt_pkg::FIELD_ID_W-1:0] {
   F_ITOW, F_YEAR, F_MONTH, F_DAY, F_HOUR, F_MINUTE, F_SECOND, F_NANO, F_FIX,
   F_LAT, F_LON, F_VEL_N, F_VEL_E, F_VEL_D, F_HEADING, F_GSPEED, F_HMSL, F_HELL,
   F_DOP, F_SACC, F_HACC, F_VACC, F_NUM_SV
} field_id_type;

localparam int FIX_POS = 20;

class pvt_scoreboard;
   parse_phase_type           phase;
   int unsigned               byte_count;
   int unsigned               frame_length;
   logic [7:0]                sum_a, sum_b, rx_cka;
   logic [7:0]                store [ubxpvt_pkg::STORE_DEPTH];
   logic [15:0]               overflow_count;
   logic [15:0]               fix_count;
   ubxpvt_pkg::rsp_item_type  expected_q [$];
   ubxpvt_pkg::rsp_item_type  step_q [$];
   int                        errors, bytes_seen, results_seen;
   int                        good_frames, fix_frames_seen, csum_fails, hdr_fails, overflows;

   function new();
      phase          = HUNT_SYNC1;
      byte_count     = 0;
      frame_length   = 0;
      sum_a          = '0;
      sum_b          = '0;
      rx_cka         = '0;
      overflow_count = '0;
      fix_count      = '0;
      foreach (store[k]) store[k] = '0;
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR: %s", msg);
   endtask

   function int pending();
      return expected_q.size();
   endfunction

   function logic [7:0] rd8(int unsigned off);
      return (off < ubxpvt_pkg::STORE_DEPTH) ? store[off] : 8'h00;
   endfunction

   function logic [31:0] rd32(int unsigned off);
      return {rd8(off + 3), rd8(off + 2), rd8(off + 1), rd8(off)};
   endfunction

   function void emit(ubxpvt_pkg::status_type st, logic [ubxpvt_pkg::FIELD_ID_W-1:0] id,
                      logic signed [ubxpvt_pkg::VALUE_W-1:0] v);
      ubxpvt_pkg::rsp_item_type r;
      r.status          = st;
      r.field_id        = id;
      r.field_value     = v;
      r.last            = 1'b0;
      r.overflow_total  = '0;
      r.fix_frame_total = '0;
      step_q.push_back(r);
   endfunction

   function void emit_u1(field_id_type id, int unsigned off);
      emit(ubxpvt_pkg::ST_FIELD, id, {25'b0, rd8(off)});
   endfunction

   function void emit_u2(field_id_type id, int unsigned off);
      emit(ubxpvt_pkg::ST_FIELD, id, {17'b0, rd8(off + 1), rd8(off)});
   endfunction

   function void emit_u4(field_id_type id, int unsigned off);
      emit(ubxpvt_pkg::ST_FIELD, id, {1'b0, rd32(off)});
   endfunction

   function void emit_i4(field_id_type id, int unsigned off);
      logic [31:0] w;
      w = rd32(off);
      emit(ubxpvt_pkg::ST_FIELD, id, {w[31], w});
   endfunction

   function void add_sum(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
   endfunction

   function void emit_fields();
      logic [7:0] fix;
      bit         full;
      fix  = rd8(FIX_POS);
      full = (fix == ubxpvt_pkg::FIX_3D) || (fix == ubxpvt_pkg::FIX_GNSS_DR);
      good_frames++;
      if (full) begin
         fix_count++;
         fix_frames_seen++;
      end
      emit_u4(F_ITOW, 0);
      emit_u2(F_YEAR, 4);
      emit_u1(F_MONTH, 6);
      emit_u1(F_DAY, 7);
      emit_u1(F_HOUR, 8);
      emit_u1(F_MINUTE, 9);
      emit_u1(F_SECOND, 10);
      emit_i4(F_NANO, 16);
      emit_u1(F_FIX, FIX_POS);
      if (full) begin
         emit_i4(F_LAT, 28);
         emit_i4(F_LON, 24);
         emit_i4(F_VEL_N, 48);
         emit_i4(F_VEL_E, 52);
         emit_i4(F_VEL_D, 56);
         emit_i4(F_HEADING, 64);
         emit_i4(F_GSPEED, 60);
         emit_i4(F_HMSL, 36);
         emit_i4(F_HELL, 32);
         emit_u2(F_DOP, 76);
         emit_u4(F_SACC, 68);
         emit_u4(F_HACC, 40);
         emit_u4(F_VACC, 44);
         emit_u1(F_NUM_SV, 23);
      end
   endfunction

   function void note_byte(logic [7:0] b);
      int unsigned i;
      bit          hdr_bad;
      step_q.delete();
      hdr_bad = 1'b0;
      bytes_seen++;
      if (byte_count >= ubxpvt_pkg::MAX_FRAME_BYTES) begin
         overflow_count++;
         overflows++;
         phase      = HUNT_SYNC1;
         byte_count = 0;
         emit(ubxpvt_pkg::ST_OVF, '0, '0);
      end else begin
         i = byte_count;
         byte_count++;
         if (i >= ubxpvt_pkg::STORE_LO && i - ubxpvt_pkg::STORE_LO < ubxpvt_pkg::STORE_DEPTH)
            store[i - ubxpvt_pkg::STORE_LO] = b;
         case (phase)
            HUNT_SYNC1: begin
               if (b == ubxpvt_pkg::SYNC_1) begin
                  phase = HUNT_SYNC2;
                  sum_a = '0;
                  sum_b = '0;
                  emit(ubxpvt_pkg::ST_BYTE, '0, '0);
               end else hdr_bad = 1'b1;
            end
            HUNT_SYNC2: begin
               if (b == ubxpvt_pkg::SYNC_2) begin
                  phase = WANT_CLASS;
                  emit(ubxpvt_pkg::ST_BYTE, '0, '0);
               end else hdr_bad = 1'b1;
            end
            WANT_CLASS: begin
               if (b == ubxpvt_pkg::MSG_CLASS) begin
                  add_sum(b);
                  phase = WANT_ID;
                  emit(ubxpvt_pkg::ST_BYTE, '0, '0);
               end else hdr_bad = 1'b1;
            end
            WANT_ID: begin
               if (b == ubxpvt_pkg::MSG_ID) begin
                  add_sum(b);
                  phase = GET_LEN;
                  emit(ubxpvt_pkg::ST_BYTE, '0, '0);
               end else hdr_bad = 1'b1;
            end
            GET_LEN: begin
               add_sum(b);
               if (i == ubxpvt_pkg::LEN_LO_INDEX) frame_length = b;
               else begin
                  frame_length = ubxpvt_pkg::FRAME_OVERHEAD +
                                 ((frame_length & 32'hFF) | (32'(b) << 8));
                  phase = GET_BODY;
               end
               emit(ubxpvt_pkg::ST_BYTE, '0, '0);
            end
            default: begin
               if (i + 1 < frame_length) begin
                  if (i + 3 <= frame_length) add_sum(b);
                  else rx_cka = b;
                  emit(ubxpvt_pkg::ST_BYTE, '0, '0);
               end else begin
                  phase      = HUNT_SYNC1;
                  byte_count = 0;
                  if (sum_a != rx_cka || sum_b != b) begin
                     csum_fails++;
                     emit(ubxpvt_pkg::ST_CSUM, '0, '0);
                  end else emit_fields();
               end
            end
         endcase
         if (hdr_bad) begin
            hdr_fails++;
            phase      = HUNT_SYNC1;
            byte_count = 0;
            emit(ubxpvt_pkg::ST_HDR, '0, '0);
         end
      end
      foreach (step_q[k]) begin
         step_q[k].overflow_total  = overflow_count;
         step_q[k].fix_frame_total = fix_count;
         step_q[k].last            = (k == step_q.size() - 1);
         expected_q.push_back(step_q[k]);
      end
   endfunction

   task check_result(ubxpvt_pkg::rsp_item_type got);
      ubxpvt_pkg::rsp_item_type want;
      results_seen++;
      if (expected_q.size() == 0) begin
         report($sformatf("result %0d arrived with nothing expected (status %0d id %0d)",
                          results_seen, got.status, got.field_id));
      end else begin
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report($sformatf("result %0d: status %0d, expected %0d",
                             results_seen, got.status, want.status));
         if (got.field_id !== want.field_id)
            report($sformatf("result %0d: field_id %0d, expected %0d",
                             results_seen, got.field_id, want.field_id));
         if (got.field_value !== want.field_value)
            report($sformatf("result %0d (field %0d): value %0d, expected %0d",
                             results_seen, want.field_id, got.field_value,
                             want.field_value));
         if (got.last !== want.last)
            report($sformatf("result %0d: last %b, expected %b",
                             results_seen, got.last, want.last));
         if (got.overflow_total !== want.overflow_total)
            report($sformatf("result %0d: overflow_total %0d, expected %0d",
                             results_seen, got.overflow_total, want.overflow_total));
         if (got.fix_frame_total !== want.fix_frame_total)
            report($sformatf("result %0d: fix_frame_total %0d, expected %0d",
                             results_seen, got.fix_frame_total, want.fix_frame_total));
      end
   endtask
endclass

module tb;
   localparam int LIMIT        = 5_000_000;
   localparam int RANDOM_BYTES = 60;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 300;
   localparam int KEEP_FILL    = -1;
   localparam int FIX_2D       = 2;

   typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_MIN_INT, FILL_MAX_INT} fill_type;
   typedef enum int {
      FLAW_NONE, FLAW_CKA, FLAW_CKB, FLAW_SYNC1, FLAW_SYNC2, FLAW_CLASS, FLAW_ID
   } flaw_type;

   logic                      clock = 1'b0;
   logic                      reset;
   ubxpvt_req_if              byte_ch ();
   ubxpvt_rsp_if              result_ch ();
   pvt_scoreboard             sb = new();
   ubxpvt_pkg::rsp_item_type  seen_item;
   int                        cycle_count = 0;
   int                        sent_bytes = 0;
   bit                        burst = 1'b0;
   bit                        hold_done = 1'b0;

   ubx_nav_pvt_frame_parser u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (byte_ch),
      .rsp_ch (result_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("Timed out after %0d cycles with %0d results pending",
                  cycle_count, sb.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (byte_ch.valid && byte_ch.ready) sb.note_byte(byte_ch.in_byte);
         if (result_ch.valid && result_ch.ready) begin
            seen_item.status          = ubxpvt_pkg::status_type'(result_ch.status);
            seen_item.field_id        = result_ch.field_id;
            seen_item.field_value     = result_ch.field_value;
            seen_item.last            = result_ch.last;
            seen_item.overflow_total  = result_ch.overflow_total;
            seen_item.fix_frame_total = result_ch.fix_frame_total;
            sb.check_result(seen_item);
         end
      end
   end

   // result side: random stalls, plus one long hold-off to back up the input
   initial begin
      int r;
      int run;
      result_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!hold_done && sb.bytes_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            result_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               result_ch.ready <= 1'b1;
               run = $urandom_range(1, 20);
            end else if (r < 80) begin
               result_ch.ready <= 1'b1;
               run = $urandom_range(50, 150);
            end else if (r < 95) begin
               result_ch.ready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               result_ch.ready <= 1'b0;
               run = $urandom_range(10, 30);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         byte_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      byte_ch.valid   <= 1'b1;
      byte_ch.in_byte <= b;
      do @(posedge clock); while (byte_ch.ready !== 1'b1);
      sent_bytes++;
   endtask

   function automatic byte_q_type make_body(input int n, input fill_type fill, input int fix);
      byte_q_type body;
      logic [7:0] v;
      for (int k = 0; k < n; k++) begin
         case (fill)
            FILL_ONES:    v = 8'hFF;
            FILL_ZEROS:   v = 8'h00;
            FILL_MIN_INT: v = (k % 4 == 3) ? 8'h80 : 8'h00;
            FILL_MAX_INT: v = (k % 4 == 3) ? 8'h7F : 8'hFF;
            default:      v = 8'($urandom_range(0, 255));
         endcase
         body.push_back(v);
      end
      if (fix != KEEP_FILL && n > FIX_POS) body[FIX_POS] = 8'(fix);
      return body;
   endfunction

   task automatic send_frame(input byte_q_type body, input int len_field, input flaw_type flaw);
      byte_q_type frame;
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic [7:0] flip;
      frame = {ubxpvt_pkg::SYNC_1, ubxpvt_pkg::SYNC_2, ubxpvt_pkg::MSG_CLASS,
               ubxpvt_pkg::MSG_ID, len_field[7:0], len_field[15:8]};
      frame = {frame, body};
      ck_a  = '0;
      ck_b  = '0;
      for (int k = 2; k < frame.size(); k++) begin
         ck_a = ck_a + frame[k];
         ck_b = ck_b + ck_a;
      end
      flip = 8'($urandom_range(1, 255));
      case (flaw)
         FLAW_CKA:   ck_a     = ck_a ^ flip;
         FLAW_CKB:   ck_b     = ck_b ^ flip;
         FLAW_SYNC1: frame[0] = frame[0] ^ flip;
         FLAW_SYNC2: frame[1] = frame[1] ^ flip;
         FLAW_CLASS: frame[2] = frame[2] ^ flip;
         FLAW_ID:    frame[3] = frame[3] ^ flip;
         default: ;
      endcase
      frame.push_back(ck_a);
      frame.push_back(ck_b);
      foreach (frame[k]) send_byte(frame[k]);
   endtask

   initial begin
      byte_q_type body;
      int         r;
      int         n;
      int         fix;
      int         base;
      fill_type   fill;
      flaw_type   flaw;
      reset           <= 1'b1;
      byte_ch.valid   <= 1'b0;
      byte_ch.in_byte <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: noise extremes, a repeated sync byte, every header and checksum flaw
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(ubxpvt_pkg::SYNC_1);
      send_byte(ubxpvt_pkg::SYNC_1);
      send_frame(make_body(78, FILL_ONES, int'(ubxpvt_pkg::FIX_3D)), 78, FLAW_NONE);
      send_frame(make_body(0, FILL_RANDOM, KEEP_FILL), 0, FLAW_NONE);
      send_frame(make_body(0, FILL_RANDOM, KEEP_FILL), 0, FLAW_SYNC1);
      send_frame(make_body(0, FILL_RANDOM, KEEP_FILL), 0, FLAW_SYNC2);
      send_frame(make_body(0, FILL_RANDOM, KEEP_FILL), 0, FLAW_CLASS);
      send_frame(make_body(0, FILL_RANDOM, KEEP_FILL), 0, FLAW_ID);
      send_frame(make_body(0, FILL_RANDOM, KEEP_FILL), 0, FLAW_CKA);
      send_frame(make_body(0, FILL_RANDOM, KEEP_FILL), 0, FLAW_CKB);
      // frame one byte longer than the bound: its last checksum byte overflows
      send_frame(make_body(ubxpvt_pkg::MAX_FRAME_BYTES - ubxpvt_pkg::FRAME_OVERHEAD + 1,
                           FILL_RANDOM, KEEP_FILL),
                 ubxpvt_pkg::MAX_FRAME_BYTES - ubxpvt_pkg::FRAME_OVERHEAD + 1, FLAW_NONE);

      // random: mostly well-formed frames, some broken ones and loose bytes
      base = sent_bytes;
      while (sent_bytes - base < RANDOM_BYTES) begin
         burst = ($urandom_range(0, 4) == 0);
         r     = $urandom_range(0, 99);
         if (r < 90) begin
            n = $urandom_range(0, 99);
            if (n < 70) n = $urandom_range(0, 30);
            else if (n < 90) n = $urandom_range(31, 91);
            else n = 92;
            if ($urandom_range(0, 1) == 1)
               fix = ($urandom_range(0, 1) == 1) ? int'(ubxpvt_pkg::FIX_3D) :
                                                   int'(ubxpvt_pkg::FIX_GNSS_DR);
            else fix = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
               0:       fill = FILL_ONES;
               1:       fill = FILL_ZEROS;
               2:       fill = FILL_MIN_INT;
               3:       fill = FILL_MAX_INT;
               default: fill = FILL_RANDOM;
            endcase
            if (r < 65) flaw = FLAW_NONE;
            else if (r < 77) flaw = ($urandom_range(0, 1) == 1) ? FLAW_CKA : FLAW_CKB;
            else flaw = flaw_type'($urandom_range(int'(FLAW_SYNC1), int'(FLAW_ID)));
            send_frame(make_body(n, fill, fix), n, flaw);
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(($urandom_range(0, 3) == 0) ? ubxpvt_pkg::SYNC_1 :
                                                       8'($urandom_range(0, 255)));
         end
      end
      burst = 1'b0;
      byte_ch.valid <= 1'b0;

      while (sb.pending() != 0 || sb.bytes_seen != sent_bytes) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d bytes and %0d results in %0d cycles, with one long output stall.",
               sb.bytes_seen, sb.results_seen, cycle_count);
      $display("Frames: %0d good (%0d with a position fix), %0d bad checksum, %0d header",
               sb.good_frames, sb.fix_frames_seen, sb.csum_fails, sb.hdr_fails);
      $display("breaks, %0d overflows.", sb.overflows);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

### files.f
+incdir+rtl
rtl/ubxpvt_pkg.sv
rtl/ubxpvt_if.sv
rtl/ubx_nav_pvt_frame_parser.sv
sim/tb.sv
